>>> sv/folr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the log ring.
`timescale 1ns / 1ps
`default_nettype none

package folr_pkg;

    // Default geometry
    localparam int FOLR_CAPACITY = 8;
    localparam int FOLR_MSG_MAX  = 32;

    // Field widths
    localparam int LEVEL_W = 3;
    localparam int TIME_W  = 32;
    localparam int CHAR_W  = 8;
    localparam int LIMIT_W = 6;

    // Stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = LEVEL_W + TIME_W + CHAR_W + LIMIT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = LEVEL_W + TIME_W + CHAR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_SEV_THRESHOLD = 1'b0;  // word index of the threshold register
    localparam logic [LEVEL_W-1:0] SEV_THRESHOLD_RESET = 3'd3;

    // Request kinds carried on s_tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Terminating character of a message
    localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_item;  // accept one write character
        logic rd_item;  // accept a read request, fetch record header
        logic rd_meta;  // header available, set up the read
        logic emit;     // stream characters into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic emit_done;  // final result of the read loaded into the output register
    } status_t;

endpackage

`default_nettype wire

>>> sv/folr_ram.sv
// Generic simple dual-port RAM with registered, enabled read.
`timescale 1ns / 1ps
`default_nettype none

module folr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/folr_ctrl.sv
// Controller state machine: sequences write characters and read requests.
`timescale 1ns / 1ps
`default_nettype none

module folr_ctrl
    import folr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    input  wire logic    s_func,
    input  wire status_t status,
    output      cmd_t    cmd,
    output      logic    s_tready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   tready_reg, tready_next;
    logic   accept;

    assign accept = s_tvalid && tready_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_func == FUNC_READ) begin
                    state_next = ST_META;
                end
            end
            ST_META: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        tready_next = (state_next == ST_IDLE);
    end

    // Decode commands
    always_comb begin
        cmd.wr_item = (state_reg == ST_IDLE) && accept && (s_func == FUNC_WRITE);
        cmd.rd_item = (state_reg == ST_IDLE) && accept && (s_func == FUNC_READ);
        cmd.rd_meta = (state_reg == ST_META);
        cmd.emit    = (state_reg == ST_EMIT);
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tready_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            tready_reg <= tready_next;
        end
    end

    assign s_tready = tready_reg;

endmodule

`default_nettype wire

>>> sv/folr_dpath.sv
// Datapath: ring pointers, run tracking, record memories and the output register.
`timescale 1ns / 1ps
`default_nettype none

module folr_dpath
    import folr_pkg::*;
#(
    parameter int CAPACITY = FOLR_CAPACITY,
    parameter int MSG_MAX  = FOLR_MSG_MAX
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output      status_t            status,
    input  wire logic [LEVEL_W-1:0] severity_threshold,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic [TIME_W-1:0]  timestamp,
    input  wire logic [CHAR_W-1:0]  msg_char,
    input  wire logic               msg_end,
    input  wire logic [LIMIT_W-1:0] read_limit,
    input  wire logic               m_tready,
    output      logic               m_tvalid,
    output      logic               found,
    output      logic [LEVEL_W-1:0] rec_level,
    output      logic [TIME_W-1:0]  rec_time,
    output      logic [CHAR_W-1:0]  out_char,
    output      logic               last
);

    localparam int PW        = $clog2(CAPACITY);
    localparam int LW        = $clog2(MSG_MAX);
    localparam int CW        = (LW > LIMIT_W) ? LW : LIMIT_W;
    localparam int MW        = LW + TIME_W + LEVEL_W;
    localparam int TXT_DEPTH = CAPACITY * (2 ** LW);
    localparam int TAW       = PW + LW;
    localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);
    localparam logic [LW-1:0] MAX_COUNT = LW'(MSG_MAX - 1);

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    // Ring and run state
    logic [PW-1:0]      wptr_reg, rptr_reg;
    logic               run_active_reg, run_acc_reg, run_closed_reg;
    logic [LW-1:0]      run_count_reg;
    logic [LEVEL_W-1:0] run_level_reg;
    logic [TIME_W-1:0]  run_time_reg;

    // Read setup and streaming state
    logic [LIMIT_W-1:0] limit_reg;
    logic [PW-1:0]      rslot_reg;
    logic               found_reg, mask_reg;
    logic [LEVEL_W-1:0] hdr_level_reg;
    logic [TIME_W-1:0]  hdr_time_reg;
    logic [LW-1:0]      cnt_reg, rd_idx_reg, ld_idx_reg;
    logic               pend_reg;

    // Output register
    logic               m_valid_reg, m_found_reg, m_last_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    logic [TIME_W-1:0]  m_time_reg;
    logic [CHAR_W-1:0]  m_char_reg;

    // Memory ports
    logic               meta_we;
    logic [MW-1:0]      meta_wdata, meta_rdata;
    logic               txt_we, txt_re;
    logic [TAW-1:0]     txt_waddr, txt_raddr;
    logic [CHAR_W-1:0]  txt_rdata;

    // Write-side decode
    logic               first, acc, closed, store, closed_n, evict;
    logic [LW-1:0]      count, count_n;
    logic [LEVEL_W-1:0] lvl_w;
    logic [TIME_W-1:0]  time_w;

    always_comb begin
        first    = !run_active_reg;
        acc      = first ? (level <= severity_threshold) : run_acc_reg;
        closed   = first ? 1'b0 : run_closed_reg;
        count    = first ? '0 : run_count_reg;
        lvl_w    = first ? level : run_level_reg;
        time_w   = first ? timestamp : run_time_reg;
        store    = acc && !closed && (msg_char != NUL_CHAR) && (count < MAX_COUNT);
        closed_n = closed || (acc && msg_char == NUL_CHAR);
        count_n  = store ? count + LW'(1) : count;
        evict    = cmd.wr_item && first && acc && (next_slot(wptr_reg) == rptr_reg);
    end

    assign txt_we     = cmd.wr_item && store;
    assign txt_waddr  = {wptr_reg, count};
    assign meta_we    = cmd.wr_item && msg_end && acc;
    assign meta_wdata = {count_n, time_w, lvl_w};

    // Read setup: clamp the character count to the reader's buffer
    logic               empty;
    logic [LW-1:0]      meta_len;
    logic [LIMIT_W-1:0] lim_m1;
    logic [CW-1:0]      lim_ext, len_ext;
    logic [LW-1:0]      n_chars;

    always_comb begin
        empty    = (rptr_reg == wptr_reg);
        meta_len = meta_rdata[MW-1 -: LW];
        lim_m1   = (limit_reg == '0) ? '0 : limit_reg - LIMIT_W'(1);
        lim_ext  = CW'(lim_m1);
        len_ext  = CW'(meta_len);
        n_chars  = (lim_ext < len_ext) ? LW'(lim_ext) : meta_len;
    end

    // Streaming: issue text reads and load results
    logic load, issue, last_ld;

    always_comb begin
        load    = cmd.emit && pend_reg && (!m_valid_reg || m_tready);
        issue   = cmd.emit && (rd_idx_reg < cnt_reg) && (!pend_reg || load);
        last_ld = (ld_idx_reg == cnt_reg - LW'(1));
    end

    assign txt_re           = issue;
    assign txt_raddr        = {rslot_reg, rd_idx_reg};
    assign status.emit_done = load && last_ld;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg       <= '0;
            rptr_reg       <= '0;
            run_active_reg <= 1'b0;
            run_acc_reg    <= 1'b0;
            run_closed_reg <= 1'b0;
            run_count_reg  <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Advance the run; close and commit on msg_end
            if (cmd.wr_item) begin
                if (msg_end) begin
                    run_active_reg <= 1'b0;
                    run_acc_reg    <= 1'b0;
                    run_closed_reg <= 1'b0;
                    run_count_reg  <= '0;
                    if (acc) begin
                        wptr_reg <= next_slot(wptr_reg);
                    end
                end else begin
                    run_active_reg <= 1'b1;
                    run_acc_reg    <= acc;
                    run_closed_reg <= closed_n;
                    run_count_reg  <= count_n;
                end
            end
            // Drop the oldest record on overflow, free the slot on read
            if (evict || (cmd.rd_meta && !empty)) begin
                rptr_reg <= next_slot(rptr_reg);
            end
            // Track the text read in flight
            if (issue) begin
                pend_reg <= 1'b1;
            end else if (load) begin
                pend_reg <= 1'b0;
            end
            // Hold the result until taken
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.wr_item && first) begin
            run_level_reg <= level;
            run_time_reg  <= timestamp;
        end
        if (cmd.rd_item) begin
            limit_reg <= read_limit;
        end
        if (cmd.rd_meta) begin
            rslot_reg     <= rptr_reg;
            found_reg     <= !empty;
            mask_reg      <= empty || (n_chars == '0);
            cnt_reg       <= (empty || n_chars == '0) ? LW'(1) : n_chars;
            hdr_level_reg <= empty ? '0 : meta_rdata[LEVEL_W-1:0];
            hdr_time_reg  <= empty ? '0 : meta_rdata[LEVEL_W +: TIME_W];
            rd_idx_reg    <= '0;
            ld_idx_reg    <= '0;
        end else begin
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + LW'(1);
            end
            if (load) begin
                ld_idx_reg <= ld_idx_reg + LW'(1);
            end
        end
        if (load) begin
            m_found_reg <= found_reg;
            m_level_reg <= hdr_level_reg;
            m_time_reg  <= hdr_time_reg;
            m_char_reg  <= mask_reg ? NUL_CHAR : txt_rdata;
            m_last_reg  <= last_ld;
        end
    end

    // Record header store: level, time and length per slot
    folr_ram #(
        .WIDTH (MW),
        .DEPTH (CAPACITY)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (wptr_reg),
        .wdata (meta_wdata),
        .re    (cmd.rd_item),
        .raddr (rptr_reg),
        .rdata (meta_rdata)
    );

    // Message text store: MSG_MAX rounded up to a power of two characters per slot
    folr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (TXT_DEPTH)
    ) u_text_ram (
        .aclk  (aclk),
        .we    (txt_we),
        .waddr (txt_waddr),
        .wdata (msg_char),
        .re    (txt_re),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    assign m_tvalid  = m_valid_reg;
    assign found     = m_found_reg;
    assign rec_level = m_level_reg;
    assign rec_time  = m_time_reg;
    assign out_char  = m_char_reg;
    assign last      = m_last_reg;

endmodule

`default_nettype wire

>>> sv/filtered_overwriting_log_ring.sv
// Top level of the filtered, overwriting log record ring.
//
// Input stream (s_*): s_tuser=0 is a write request carrying one message character;
// s_tlast closes the run and commits the record. Level and timestamp come from the
// run's first request; a run above severity_threshold is dropped, and when the ring
// is full the run's first request evicts the oldest record. s_tuser=1 is a read
// request for the oldest record.
// Write requests may arrive back to back.
// A read request holds s_tready low until its final result is loaded. It yields
// N results (1 to MSG_MAX-1): the record header is read, the text memory is
// started, then one result per cycle comes from its read port while m_tready is high.
// m_tlast marks the final result of a read; m_tuser=0 says the ring was empty.
// A stalled receiver holds the output register and pauses the text stream; write
// requests are still taken while a finished result waits.
// Reset (aresetn low, synchronous) empties the ring and sets the threshold to 3;
// the memories are not cleared and need no clearing pass.
// severity_threshold sits at APB byte address 0; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module filtered_overwriting_log_ring
    import folr_pkg::*;
#(
    parameter int CAPACITY = FOLR_CAPACITY,
    parameter int MSG_MAX  = FOLR_MSG_MAX
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // level, timestamp, msg_char, read_limit
    input  wire logic                  s_tlast,   // msg_end
    input  wire logic                  s_tuser,   // func
    // Result stream
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [M_TDATA_W-1:0]  m_tdata,   // rec_level, rec_time, out_char
    output      logic                  m_tlast,   // last
    output      logic                  m_tuser,   // found
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    cmd_t               cmd;
    status_t            status;
    logic [LEVEL_W-1:0] thr_reg;
    logic               cfg_wr;
    logic [LEVEL_W-1:0] in_level;
    logic [TIME_W-1:0]  in_time;
    logic [CHAR_W-1:0]  in_char;
    logic [LIMIT_W-1:0] in_limit;
    logic [LEVEL_W-1:0] res_level;
    logic [TIME_W-1:0]  out_time;
    logic [CHAR_W-1:0]  out_char;

    // Unpack the request
    assign in_level = s_tdata[0 +: LEVEL_W];
    assign in_time  = s_tdata[LEVEL_W +: TIME_W];
    assign in_char  = s_tdata[LEVEL_W + TIME_W +: CHAR_W];
    assign in_limit = s_tdata[LEVEL_W + TIME_W + CHAR_W +: LIMIT_W];

    // Threshold register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SEV_THRESHOLD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= SEV_THRESHOLD_RESET;
        end else if (cfg_wr) begin
            thr_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SEV_THRESHOLD) ?
                    {{(APB_DATA_W - LEVEL_W){1'b0}}, thr_reg} : '0;

    folr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    folr_dpath #(
        .CAPACITY (CAPACITY),
        .MSG_MAX  (MSG_MAX)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .severity_threshold (thr_reg),
        .level              (in_level),
        .timestamp          (in_time),
        .msg_char           (in_char),
        .msg_end            (s_tlast),
        .read_limit         (in_limit),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .found              (m_tuser),
        .rec_level          (res_level),
        .rec_time           (out_time),
        .out_char           (out_char),
        .last               (m_tlast)
    );

    // Pack the result
    assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_char, out_time, res_level};

endmodule

`default_nettype wire

>>> sv/folr_checker.sv
// Port-level checker for the log ring, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module folr_checker
    import folr_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast,
    input wire logic                 m_tuser
);

    // A read request stops further requests until its results are out
    a_read_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_READ) |=> !s_tready)
        else $error("input taken right after a read request");

    // Input reopens only once the final result of the read is presented
    a_reopen_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) && $past(aresetn) |-> m_tvalid && m_tlast)
        else $error("input reopened before the last result was loaded");

    // A not-found result is a single, all-zero result
    a_not_found_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("malformed not-found result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind filtered_overwriting_log_ring folr_checker u_folr_checker (.*);

`default_nettype wire

>>> bench/tb_filtered_overwriting_log_ring.sv
// Self-checking bench for the filtered, overwriting log record ring.
`timescale 1ns / 1ps

module tb_filtered_overwriting_log_ring;
    import folr_pkg::*;

    localparam int CAP          = FOLR_CAPACITY;
    localparam int TEXT_MAX     = FOLR_MSG_MAX;
    localparam int LIMIT_CYCLES = 800_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 48;
    localparam int ERR_SHOWN    = 10;

    // Values of the found flag
    localparam logic REC_NOT_FOUND = 1'b0;
    localparam logic REC_FOUND     = 1'b1;

    typedef struct packed {
        logic               func;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  ts;
        logic [CHAR_W-1:0]  ch;
        logic               eom;
        logic [LIMIT_W-1:0] limit;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  ts;
        logic [CHAR_W-1:0]  ch;
        logic               last;
    } res_t;

    // One directed request; typed rows carry their single result inline
    typedef struct packed {
        logic               func;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  ts;
        logic [CHAR_W-1:0]  ch;
        logic               eom;
        logic [LIMIT_W-1:0] limit;
        logic               typed;
        logic               x_found;
        logic [LEVEL_W-1:0] x_level;
        logic [TIME_W-1:0]  x_time;
        logic [CHAR_W-1:0]  x_char;
    } dir_row_t;

    localparam int DIR_N = 23;
    localparam dir_row_t DIRECTED [DIR_N] = '{
        // empty ring right after reset
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd5,  1'b1, REC_NOT_FOUND, 3'd0, 32'h0, 8'h00},
        // single-item run, then nothing to copy with limit 0
        '{FUNC_WRITE, 3'd0, 32'hFFFF_FFFF, 8'h41, 1'b1, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd0,  1'b1, REC_FOUND, 3'd0, 32'hFFFF_FFFF, 8'h00},
        // run above threshold is dropped up to its end
        '{FUNC_WRITE, 3'd7, 32'h0000_0000, 8'hFF, 1'b0, 6'd63, 1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_WRITE, 3'd0, 32'h0000_0001, 8'h11, 1'b1, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd32, 1'b1, REC_NOT_FOUND, 3'd0, 32'h0, 8'h00},
        // text after NUL ignored; limit 1 copies nothing
        '{FUNC_WRITE, 3'd3, 32'h0000_0000, 8'h80, 1'b0, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_WRITE, 3'd0, 32'h0000_0005, 8'h00, 1'b0, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_WRITE, 3'd0, 32'h0000_0005, 8'h55, 1'b1, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd1,  1'b1, REC_FOUND, 3'd3, 32'h0, 8'h00},
        // level and time come from the first item only; long limit
        '{FUNC_WRITE, 3'd2, 32'h1234_5678, 8'h78, 1'b0, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_WRITE, 3'd6, 32'h0000_0000, 8'h79, 1'b0, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_WRITE, 3'd2, 32'h0000_0000, 8'hFF, 1'b1, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd63, 1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        // empty text
        '{FUNC_WRITE, 3'd1, 32'hA5A5_A5A5, 8'h00, 1'b1, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd32, 1'b1, REC_FOUND, 3'd1, 32'hA5A5_A5A5, 8'h00},
        // read during an open run sees nothing
        '{FUNC_WRITE, 3'd1, 32'h5A5A_5A5A, 8'h61, 1'b0, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd10, 1'b1, REC_NOT_FOUND, 3'd0, 32'h0, 8'h00},
        '{FUNC_WRITE, 3'd1, 32'h0000_0000, 8'h62, 1'b1, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd2,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        // level at the threshold is kept
        '{FUNC_WRITE, 3'd3, 32'h0000_0007, 8'h01, 1'b1, 6'd0,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd3,  1'b0, 1'b0, 3'd0, 32'h0, 8'h00},
        '{FUNC_READ,  3'd0, 32'h0000_0000, 8'h00, 1'b0, 6'd33, 1'b1, REC_NOT_FOUND, 3'd0, 32'h0, 8'h00}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // level, timestamp, msg_char, read_limit
    logic                  s_tlast;   // msg_end
    logic                  s_tuser;   // func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // rec_level, rec_time, out_char
    logic                  m_tlast;   // last
    logic                  m_tuser;   // found
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    filtered_overwriting_log_ring dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the ring
    logic [LEVEL_W-1:0] shadow_level [CAP];
    logic [TIME_W-1:0]  shadow_time  [CAP];
    logic [CHAR_W-1:0]  shadow_text  [CAP][TEXT_MAX];
    int                 shadow_len   [CAP];
    int                 wr_slot      = 0;
    int                 rd_slot      = 0;
    logic               run_open     = 1'b0;
    logic               run_kept     = 1'b0;
    logic               run_nul_seen = 1'b0;
    int                 run_chars    = 0;
    logic [LEVEL_W-1:0] threshold    = SEV_THRESHOLD_RESET;

    res_t fresh_results [$];
    res_t owed_results  [$];

    int  mismatches  = 0;
    int  phase_items = 0;
    int  cycle_count = 0;
    bit  quiet       = 1'b0;
    bit  hold_off    = 1'b0;

    function automatic int ring_next(int p);
        return (p + 1 >= CAP) ? 0 : p + 1;
    endfunction

    // Apply one request to the shadow ring; append the results it causes
    function automatic void ring_respond(req_t r);
        int   n;
        res_t res;
        if (r.func == FUNC_WRITE) begin
            if (!run_open) begin
                run_open     = 1'b1;
                run_nul_seen = 1'b0;
                run_chars    = 0;
                run_kept     = (r.level <= threshold);
                if (run_kept) begin
                    // evict the oldest record when full
                    if (ring_next(wr_slot) == rd_slot)
                        rd_slot = ring_next(rd_slot);
                    shadow_level[wr_slot] = r.level;
                    shadow_time[wr_slot]  = r.ts;
                end
            end
            if (run_kept && !run_nul_seen) begin
                if (r.ch == NUL_CHAR) begin
                    run_nul_seen = 1'b1;
                end else if (run_chars < TEXT_MAX - 1) begin
                    shadow_text[wr_slot][run_chars] = r.ch;
                    run_chars++;
                end
            end
            if (r.eom) begin
                if (run_kept) begin
                    shadow_len[wr_slot] = run_chars;
                    wr_slot = ring_next(wr_slot);
                end
                run_open     = 1'b0;
                run_kept     = 1'b0;
                run_nul_seen = 1'b0;
                run_chars    = 0;
            end
        end else if (rd_slot == wr_slot) begin
            res = '{REC_NOT_FOUND, '0, '0, NUL_CHAR, 1'b1};
            fresh_results.push_back(res);
        end else begin
            n = (r.limit > 0) ? int'(r.limit) - 1 : 0;
            if (n > shadow_len[rd_slot])
                n = shadow_len[rd_slot];
            if (n > TEXT_MAX - 1)
                n = TEXT_MAX - 1;
            if (n == 0) begin
                res = '{REC_FOUND, shadow_level[rd_slot], shadow_time[rd_slot], NUL_CHAR, 1'b1};
                fresh_results.push_back(res);
            end else begin
                for (int k = 0; k < n; k++) begin
                    res = '{REC_FOUND, shadow_level[rd_slot], shadow_time[rd_slot],
                            shadow_text[rd_slot][k], (k == n - 1)};
                    fresh_results.push_back(res);
                end
            end
            rd_slot = ring_next(rd_slot);
        end
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= ERR_SHOWN)
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Offer one request after a random gap; predict it when taken
    task automatic send_req(input req_t r, input logic typed, input res_t typed_res);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = r.func;
        s_tlast  = r.eom;
        s_tdata  = S_TDATA_W'({r.limit, r.ch, r.ts, r.level});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ring_respond(r);
        if (typed) begin
            owed_results.push_back(typed_res);
        end else begin
            foreach (fresh_results[i]) owed_results.push_back(fresh_results[i]);
        end
        fresh_results.delete();
        phase_items++;
        @(negedge aclk);
    endtask

    task automatic send_read(input logic [LIMIT_W-1:0] limit);
        req_t r;
        r       = '0;
        r.func  = FUNC_READ;
        r.level = LEVEL_W'($urandom_range(0, 7));
        r.ts    = $urandom;
        r.ch    = CHAR_W'($urandom_range(0, 255));
        r.eom   = 1'($urandom_range(0, 1));
        r.limit = limit;
        send_req(r, 1'b0, '0);
    endtask

    task automatic send_write_run(input int len, input logic [LEVEL_W-1:0] lvl,
                                  input bit close, input bit allow_nul);
        req_t r;
        for (int k = 0; k < len; k++) begin
            r       = '0;
            r.func  = FUNC_WRITE;
            r.level = (k == 0) ? lvl : LEVEL_W'($urandom_range(0, 7));
            r.ts    = $urandom;
            r.ch    = (allow_nul && $urandom_range(0, 15) == 0) ? NUL_CHAR
                                                                : CHAR_W'($urandom_range(1, 255));
            r.eom   = close && (k == len - 1);
            r.limit = LIMIT_W'($urandom_range(0, 63));
            send_req(r, 1'b0, '0);
        end
    endtask

    // Stop offering and wait for every owed result, then for the tail of the work
    task automatic settle_ring();
        s_tvalid = 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the threshold, then read it back
    task automatic set_threshold(input logic [LEVEL_W-1:0] value);
        logic [APB_DATA_W-1:0] got;
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(REG_SEV_THRESHOLD) << 2;
        pwdata  = APB_DATA_W'(value);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        threshold = value;
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got != APB_DATA_W'(value))
            note_mismatch("threshold readback", 64'(value), 64'(got));
    endtask

    task automatic send_random_sequence(input int read_pct);
        int len;
        if ($urandom_range(0, 99) < read_pct) begin
            send_read(($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom_range(33, 63))
                                                  : LIMIT_W'($urandom_range(0, 32)));
        end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 8);
            send_write_run(len, LEVEL_W'($urandom_range(0, 7)), 1'b1, 1'b1);
        end
    endtask

    // Check each taken result against the oldest owed one
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (owed_results.size() == 0) begin
                note_mismatch("unexpected result", 64'h0, 64'(m_tdata));
            end else begin
                want = owed_results.pop_front();
                if (m_tuser !== want.found)
                    note_mismatch("found", 64'(want.found), 64'(m_tuser));
                if (m_tdata[2:0] !== want.level)
                    note_mismatch("rec_level", 64'(want.level), 64'(m_tdata[2:0]));
                if (m_tdata[34:3] !== want.ts)
                    note_mismatch("rec_time", 64'(want.ts), 64'(m_tdata[34:3]));
                if (m_tdata[42:35] !== want.ch)
                    note_mismatch("out_char", 64'(want.ch), 64'(m_tdata[42:35]));
                if (m_tlast !== want.last)
                    note_mismatch("last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    // Receiver: stall a random number of cycles before each result
    initial begin
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (hold_off) begin
                stall    = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int                 read_pct;
        logic [LEVEL_W-1:0] phase_thr;
        req_t               r;
        res_t               typed_res;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = FUNC_WRITE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Walk the directed table under the reset threshold
        for (int i = 0; i < DIR_N; i++) begin
            r         = '{DIRECTED[i].func, DIRECTED[i].level, DIRECTED[i].ts,
                          DIRECTED[i].ch, DIRECTED[i].eom, DIRECTED[i].limit};
            typed_res = '{DIRECTED[i].x_found, DIRECTED[i].x_level, DIRECTED[i].x_time,
                          DIRECTED[i].x_char, 1'b1};
            send_req(r, DIRECTED[i].typed, typed_res);
        end

        // Random phases, each under its own threshold
        for (int phase = 0; phase < 5; phase++) begin
            settle_ring();
            case (phase)
                0: begin phase_thr = 3'd7; read_pct = 40; end
                1: begin phase_thr = 3'd0; read_pct = 30; end
                2: begin phase_thr = 3'd5; read_pct = 15; end
                3: begin phase_thr = LEVEL_W'($urandom_range(1, 6)); read_pct = 60; end
                default: begin phase_thr = 3'd3; read_pct = 35; end
            endcase
            set_threshold(phase_thr);
            quiet       = (phase == 1);
            hold_off    = (phase == 2);
            phase_items = 0;
            if (phase == 0) begin
                // overlong text, read back with the widest useful limit
                send_write_run(40, 3'd0, 1'b1, 1'b0);
                send_read(LIMIT_W'(32));
            end
            if (phase == 1) begin
                // close the run opened under the previous threshold
                send_write_run(1, 3'd7, 1'b1, 1'b1);
            end
            while (phase_items < PHASE_ITEMS)
                send_random_sequence(read_pct);
            if (phase == 0) begin
                // leave a run open across the threshold change
                send_write_run(2, 3'd5, 1'b0, 1'b1);
            end
        end

        settle_ring();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
